// ----- src/tempo_from_event_intervals_macros.svh -----
// ---------------------------------------------------------------------------
// tempo_from_event_intervals assertion macros
// shared concurrent assertion forms, clocked on i_clk, held off in reset
// ---------------------------------------------------------------------------
`ifndef TEMPO_FROM_EVENT_INTERVALS_MACROS_SVH
`define TEMPO_FROM_EVENT_INTERVALS_MACROS_SVH

// same-cycle implication
`define TFEI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFEI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tfei_pkg.sv -----
// ---------------------------------------------------------------------------
// tfei_pkg
// types, register map and constant tables of the tempo estimator
// ---------------------------------------------------------------------------
package tfei_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ES_I, ST_ES_V, ST_ES_K, ST_ES_C,
        ST_SC_I, ST_SC_IW, ST_SC_J, ST_SC_JW,
        ST_LG_N, ST_LG_M, ST_LG_A, ST_SC_ST,
        ST_FR_CHK,
        ST_FS_I, ST_FS_V, ST_FS_K, ST_FS_C,
        ST_DN_I, ST_DN_IW, ST_DN_A, ST_DN_AW, ST_DN_CNT, ST_DN_VW,
        ST_PW_M, ST_PW_F,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        REG_MIN_GAP      = 2'd0,
        REG_MAX_SPAN     = 2'd1,
        REG_WINDOW_WIDTH = 2'd2,
        REG_FALLBACK_BPM = 2'd3
    } t_reg_idx;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [15:0] RST_MIN_GAP      = 16'd66;
    localparam logic [31:0] RST_MAX_SPAN     = 32'd65536;
    localparam logic [15:0] RST_WINDOW_WIDTH = 16'd655;
    localparam logic [14:0] RST_FALLBACK_BPM = 15'd15360;

    // 120 bpm in q7.8, scaled by the q1.32 product
    localparam logic [14:0] BPM_SCALE = 15'd30720;

    typedef logic [31:0] t_fac_tab [16];

    // factors 2^-(2^-k), k = 1..16, each the floor square root of the one before
    function automatic t_fac_tab fac_table();
        t_fac_tab    tab;
        logic [63:0] fac;
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        fac = 64'h0000_0000_8000_0000;
        for (int k = 0; k < 16; k++) begin
            x   = fac << 32;
            res = '0;
            b   = 64'h4000_0000_0000_0000;
            while (b > x) begin
                b = b >> 2;
            end
            while (b != 64'd0) begin
                if (x >= res + b) begin
                    x   = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            fac    = res;
            tab[k] = fac[31:0];
        end
        return tab;
    endfunction

endpackage

// ----- src/tempo_from_event_intervals.sv -----
// ---------------------------------------------------------------------------
// tempo_from_event_intervals
// tempo estimate from the log intervals between loaded event times
// ---------------------------------------------------------------------------
// input channel (i_valid / o_stall): a beat with i_operation load stores
// i_event_time in the event memory and leaves o_stall low; loads beyond
// MAX_EVENTS are dropped and flagged. a beat with i_operation compute starts
// the sequencer and gives exactly one result beat on o_valid / i_stall.
// a compute beat runs the shared sequencer over the two memories: insertion
// sort of n events, the pair scan (the log2 normalise and squaring loop per
// recorded interval, a direct store for a zero gap, a skip for one below
// r_min_gap), insertion sort of m fractions, the cyclic window pass and the
// power product. o_stall is high while the sequencer runs.
// a result waiting on i_stall does not block loads; a following compute
// holds in its last step until the output register is free.
// reset clears counts, flags and output valid, sets configuration defaults;
// memory contents are undefined until written and need no clearing pass.
// configuration over the apb port, registers at byte addresses 0, 4, 8, 12.
// ---------------------------------------------------------------------------
`include "tempo_from_event_intervals_macros.svh"

module tempo_from_event_intervals #(
    parameter int MAX_EVENTS    = 256,
    parameter int MAX_FRACTIONS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [31:0] i_event_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_bpm,
    output logic        o_used_fallback,
    output logic        o_event_overflow,
    output logic        o_log_overflow,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int EW = $clog2(MAX_EVENTS);
    localparam int FW = $clog2(MAX_FRACTIONS);
    localparam logic [EW:0] EV_MAX = (EW+1)'(MAX_EVENTS);
    localparam logic [FW:0] FR_MAX = (FW+1)'(MAX_FRACTIONS);
    localparam tfei_pkg::t_fac_tab FAC = tfei_pkg::fac_table();

    tfei_pkg::t_state r_state, n_state;

    logic [15:0] r_min_gap;
    logic [31:0] r_max_span;
    logic [15:0] r_win;
    logic [14:0] r_fb_bpm;

    logic [EW:0]   r_ev_cnt, n_ev_cnt;
    logic [FW:0]   r_fr_cnt, n_fr_cnt;
    logic          r_ev_ovf, n_ev_ovf;
    logic          r_lg_ovf, n_lg_ovf;
    logic [EW:0]   r_i, n_i, r_j, n_j, r_k, n_k;
    logic [31:0]   r_v, n_v, r_ei, n_ei, r_gap, n_gap, r_m, n_m;
    logic [63:0]   r_prod, n_prod;
    logic [15:0]   r_f, n_f;
    logic [3:0]    r_cnt, n_cnt;
    logic [FW:0]   r_fi, n_fi, r_fk, n_fk, r_best, n_best;
    logic [15:0]   r_fv, n_fv, r_val, n_val;
    logic [FW+1:0] r_after, n_after;
    logic [16:0]   r_lim, n_lim;
    logic [32:0]   r_acc, n_acc;
    logic [3:0]    r_pk, n_pk;
    logic [14:0]   r_res_bpm, n_res_bpm;
    logic          r_res_fb, n_res_fb;

    logic          r_out_valid, n_out_valid;
    logic [14:0]   r_o_bpm;
    logic          r_o_fb, r_o_eovf, r_o_lovf;
    logic          out_load;

    logic [31:0] r_ev_mem [MAX_EVENTS];
    logic [31:0] r_ev_rd;
    logic        ev_we;
    logic [EW-1:0] ev_wa, ev_ra;
    logic [31:0] ev_wd;

    logic [15:0] r_fr_mem [MAX_FRACTIONS];
    logic [15:0] r_fr_rd;
    logic        fr_we;
    logic [FW-1:0] fr_wa, fr_ra;
    logic [15:0] fr_wd;

    logic          in_acc;
    logic          cfg_wr;
    logic [31:0]   gap;
    logic [32:0]   mm;
    logic [64:0]   pw_prod;
    logic [47:0]   bpm_prod;
    logic [16:0]   win_x;
    logic [FW+1:0] cnt_run, fr_n2, mid;
    logic [FW+2:0] mid_sum;

    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != tfei_pkg::ST_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        unique case (tfei_pkg::t_reg_idx'(paddr[3:2]))
            tfei_pkg::REG_MIN_GAP:      prdata = {16'd0, r_min_gap};
            tfei_pkg::REG_MAX_SPAN:     prdata = r_max_span;
            tfei_pkg::REG_WINDOW_WIDTH: prdata = {16'd0, r_win};
            tfei_pkg::REG_FALLBACK_BPM: prdata = {17'd0, r_fb_bpm};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap  <= tfei_pkg::RST_MIN_GAP;
            r_max_span <= tfei_pkg::RST_MAX_SPAN;
            r_win      <= tfei_pkg::RST_WINDOW_WIDTH;
            r_fb_bpm   <= tfei_pkg::RST_FALLBACK_BPM;
        end else if (cfg_wr) begin
            unique case (tfei_pkg::t_reg_idx'(paddr[3:2]))
                tfei_pkg::REG_MIN_GAP:      r_min_gap  <= pwdata[15:0];
                tfei_pkg::REG_MAX_SPAN:     r_max_span <= pwdata;
                tfei_pkg::REG_WINDOW_WIDTH: r_win      <= pwdata[15:0];
                tfei_pkg::REG_FALLBACK_BPM: r_fb_bpm   <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // event and fraction memories, registered read
    always_ff @(posedge i_clk) begin
        if (ev_we) begin
            r_ev_mem[ev_wa] <= ev_wd;
        end
        r_ev_rd <= r_ev_mem[ev_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            r_fr_mem[fr_wa] <= fr_wd;
        end
        r_fr_rd <= r_fr_mem[fr_ra];
    end

    // shared datapath terms
    assign gap      = r_ev_rd - r_ei;
    assign mm       = r_prod[63:31];
    assign pw_prod  = r_acc * FAC[r_pk];
    assign bpm_prod = tfei_pkg::BPM_SCALE * r_acc;
    assign fr_n2    = {1'b0, r_fr_cnt};
    assign win_x    = (r_after < fr_n2) ? {1'b0, r_fr_rd} : {1'b1, r_fr_rd};
    assign cnt_run  = (r_after > {1'b0, r_fi}) ? (r_after - {1'b0, r_fi}) : '0;
    assign mid_sum  = {1'b0, r_after} + {2'b00, r_fi};
    assign mid      = mid_sum[FW+2:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tfei_pkg::ST_IDLE;
            r_ev_cnt    <= '0;
            r_fr_cnt    <= '0;
            r_ev_ovf    <= 1'b0;
            r_lg_ovf    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ev_cnt    <= n_ev_cnt;
            r_fr_cnt    <= n_fr_cnt;
            r_ev_ovf    <= n_ev_ovf;
            r_lg_ovf    <= n_lg_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
        r_v       <= n_v;
        r_ei      <= n_ei;
        r_gap     <= n_gap;
        r_m       <= n_m;
        r_prod    <= n_prod;
        r_f       <= n_f;
        r_cnt     <= n_cnt;
        r_fi      <= n_fi;
        r_fk      <= n_fk;
        r_best    <= n_best;
        r_fv      <= n_fv;
        r_val     <= n_val;
        r_after   <= n_after;
        r_lim     <= n_lim;
        r_acc     <= n_acc;
        r_pk      <= n_pk;
        r_res_bpm <= n_res_bpm;
        r_res_fb  <= n_res_fb;
        if (out_load) begin
            r_o_bpm  <= r_res_bpm;
            r_o_fb   <= r_res_fb;
            r_o_eovf <= r_ev_ovf;
            r_o_lovf <= r_lg_ovf;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ev_cnt  = r_ev_cnt;
        n_fr_cnt  = r_fr_cnt;
        n_ev_ovf  = r_ev_ovf;
        n_lg_ovf  = r_lg_ovf;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_v       = r_v;
        n_ei      = r_ei;
        n_gap     = r_gap;
        n_m       = r_m;
        n_prod    = r_prod;
        n_f       = r_f;
        n_cnt     = r_cnt;
        n_fi      = r_fi;
        n_fk      = r_fk;
        n_best    = r_best;
        n_fv      = r_fv;
        n_val     = r_val;
        n_after   = r_after;
        n_lim     = r_lim;
        n_acc     = r_acc;
        n_pk      = r_pk;
        n_res_bpm = r_res_bpm;
        n_res_fb  = r_res_fb;
        out_load  = 1'b0;
        ev_we     = 1'b0;
        ev_wa     = '0;
        ev_wd     = '0;
        ev_ra     = '0;
        fr_we     = 1'b0;
        fr_wa     = '0;
        fr_wd     = '0;
        fr_ra     = '0;

        unique case (r_state)
            tfei_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_operation == tfei_pkg::OP_LOAD) begin
                        if (r_ev_cnt < EV_MAX) begin
                            ev_we    = 1'b1;
                            ev_wa    = r_ev_cnt[EW-1:0];
                            ev_wd    = i_event_time;
                            n_ev_cnt = r_ev_cnt + 1'b1;
                        end else begin
                            n_ev_ovf = 1'b1;
                        end
                    end else begin
                        n_i     = (EW+1)'(1);
                        n_state = tfei_pkg::ST_ES_I;
                    end
                end
            end

            // insertion sort of the events
            tfei_pkg::ST_ES_I: begin
                if (r_i >= r_ev_cnt) begin
                    n_i     = '0;
                    n_state = tfei_pkg::ST_SC_I;
                end else begin
                    ev_ra   = r_i[EW-1:0];
                    n_k     = r_i;
                    n_state = tfei_pkg::ST_ES_V;
                end
            end
            tfei_pkg::ST_ES_V: begin
                n_v     = r_ev_rd;
                n_state = tfei_pkg::ST_ES_K;
            end
            tfei_pkg::ST_ES_K: begin
                if (r_k == '0) begin
                    ev_we   = 1'b1;
                    ev_wa   = '0;
                    ev_wd   = r_v;
                    n_i     = r_i + 1'b1;
                    n_state = tfei_pkg::ST_ES_I;
                end else begin
                    ev_ra   = EW'(r_k - 1'b1);
                    n_state = tfei_pkg::ST_ES_C;
                end
            end
            tfei_pkg::ST_ES_C: begin
                ev_we = 1'b1;
                ev_wa = r_k[EW-1:0];
                if (r_ev_rd > r_v) begin
                    ev_wd   = r_ev_rd;
                    n_k     = r_k - 1'b1;
                    n_state = tfei_pkg::ST_ES_K;
                end else begin
                    ev_wd   = r_v;
                    n_i     = r_i + 1'b1;
                    n_state = tfei_pkg::ST_ES_I;
                end
            end

            // pair scan
            tfei_pkg::ST_SC_I: begin
                if ((EW+1)'(r_i + 1'b1) >= r_ev_cnt) begin
                    n_state = tfei_pkg::ST_FR_CHK;
                end else begin
                    ev_ra   = r_i[EW-1:0];
                    n_j     = r_i + 1'b1;
                    n_state = tfei_pkg::ST_SC_IW;
                end
            end
            tfei_pkg::ST_SC_IW: begin
                n_ei    = r_ev_rd;
                n_state = tfei_pkg::ST_SC_J;
            end
            tfei_pkg::ST_SC_J: begin
                if (r_j >= r_ev_cnt) begin
                    n_i     = r_i + 1'b1;
                    n_state = tfei_pkg::ST_SC_I;
                end else begin
                    ev_ra   = r_j[EW-1:0];
                    n_state = tfei_pkg::ST_SC_JW;
                end
            end
            tfei_pkg::ST_SC_JW: begin
                n_gap = gap;
                n_m   = gap;
                n_f   = '0;
                n_cnt = '0;
                if (gap < {16'd0, r_min_gap}) begin
                    n_j     = r_j + 1'b1;
                    n_state = tfei_pkg::ST_SC_J;
                end else if (gap == '0) begin
                    n_state = tfei_pkg::ST_SC_ST;
                end else begin
                    n_state = tfei_pkg::ST_LG_N;
                end
            end

            // log2 fraction: normalise, then sixteen squarings
            tfei_pkg::ST_LG_N: begin
                if (r_m[31]) begin
                    n_state = tfei_pkg::ST_LG_M;
                end else begin
                    n_m = {r_m[30:0], 1'b0};
                end
            end
            tfei_pkg::ST_LG_M: begin
                n_prod  = r_m * r_m;
                n_state = tfei_pkg::ST_LG_A;
            end
            tfei_pkg::ST_LG_A: begin
                n_f   = {r_f[14:0], mm[32]};
                n_m   = mm[32] ? mm[32:1] : mm[31:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 4'd15) begin
                    n_state = tfei_pkg::ST_SC_ST;
                end else begin
                    n_state = tfei_pkg::ST_LG_M;
                end
            end
            tfei_pkg::ST_SC_ST: begin
                if (r_fr_cnt < FR_MAX) begin
                    fr_we    = 1'b1;
                    fr_wa    = r_fr_cnt[FW-1:0];
                    fr_wd    = r_f;
                    n_fr_cnt = r_fr_cnt + 1'b1;
                end else begin
                    n_lg_ovf = 1'b1;
                end
                if (r_gap > r_max_span) begin
                    n_i     = r_i + 1'b1;
                    n_state = tfei_pkg::ST_SC_I;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = tfei_pkg::ST_SC_J;
                end
            end

            tfei_pkg::ST_FR_CHK: begin
                n_after = '0;
                n_best  = '0;
                n_val   = '0;
                if (r_fr_cnt == '0) begin
                    n_res_bpm = r_fb_bpm;
                    n_res_fb  = 1'b1;
                    n_state   = tfei_pkg::ST_FIN;
                end else begin
                    n_res_fb = 1'b0;
                    n_fi     = (FW+1)'(1);
                    n_state  = tfei_pkg::ST_FS_I;
                end
            end

            // insertion sort of the fractions
            tfei_pkg::ST_FS_I: begin
                if (r_fi >= r_fr_cnt) begin
                    n_fi    = '0;
                    n_state = tfei_pkg::ST_DN_I;
                end else begin
                    fr_ra   = r_fi[FW-1:0];
                    n_fk    = r_fi;
                    n_state = tfei_pkg::ST_FS_V;
                end
            end
            tfei_pkg::ST_FS_V: begin
                n_fv    = r_fr_rd;
                n_state = tfei_pkg::ST_FS_K;
            end
            tfei_pkg::ST_FS_K: begin
                if (r_fk == '0) begin
                    fr_we   = 1'b1;
                    fr_wa   = '0;
                    fr_wd   = r_fv;
                    n_fi    = r_fi + 1'b1;
                    n_state = tfei_pkg::ST_FS_I;
                end else begin
                    fr_ra   = FW'(r_fk - 1'b1);
                    n_state = tfei_pkg::ST_FS_C;
                end
            end
            tfei_pkg::ST_FS_C: begin
                fr_we = 1'b1;
                fr_wa = r_fk[FW-1:0];
                if (r_fr_rd > r_fv) begin
                    fr_wd   = r_fr_rd;
                    n_fk    = r_fk - 1'b1;
                    n_state = tfei_pkg::ST_FS_K;
                end else begin
                    fr_wd   = r_fv;
                    n_fi    = r_fi + 1'b1;
                    n_state = tfei_pkg::ST_FS_I;
                end
            end

            // cyclic densest window
            tfei_pkg::ST_DN_I: begin
                if (r_fi >= r_fr_cnt) begin
                    n_acc   = 33'h1_0000_0000;
                    n_pk    = '0;
                    n_state = tfei_pkg::ST_PW_M;
                end else begin
                    fr_ra   = r_fi[FW-1:0];
                    n_state = tfei_pkg::ST_DN_IW;
                end
            end
            tfei_pkg::ST_DN_IW: begin
                n_lim   = {1'b0, r_fr_rd} + {1'b0, r_win};
                n_state = tfei_pkg::ST_DN_A;
            end
            tfei_pkg::ST_DN_A: begin
                if (r_after < ({1'b0, r_fi} + fr_n2)) begin
                    fr_ra   = (r_after < fr_n2) ? r_after[FW-1:0]
                                                : FW'(r_after - fr_n2);
                    n_state = tfei_pkg::ST_DN_AW;
                end else begin
                    n_state = tfei_pkg::ST_DN_CNT;
                end
            end
            tfei_pkg::ST_DN_AW: begin
                if (win_x < r_lim) begin
                    n_after = r_after + 1'b1;
                    n_state = tfei_pkg::ST_DN_A;
                end else begin
                    n_state = tfei_pkg::ST_DN_CNT;
                end
            end
            tfei_pkg::ST_DN_CNT: begin
                if (cnt_run > {1'b0, r_best}) begin
                    n_best  = cnt_run[FW:0];
                    fr_ra   = (mid >= fr_n2) ? FW'(mid - fr_n2) : mid[FW-1:0];
                    n_state = tfei_pkg::ST_DN_VW;
                end else begin
                    n_fi    = r_fi + 1'b1;
                    n_state = tfei_pkg::ST_DN_I;
                end
            end
            tfei_pkg::ST_DN_VW: begin
                n_val   = r_fr_rd;
                n_fi    = r_fi + 1'b1;
                n_state = tfei_pkg::ST_DN_I;
            end

            // 2^-f as a product of per-bit factors
            tfei_pkg::ST_PW_M: begin
                if (r_val[4'd15 - r_pk]) begin
                    n_acc = pw_prod[64:32];
                end
                n_pk = r_pk + 1'b1;
                if (r_pk == 4'd15) begin
                    n_state = tfei_pkg::ST_PW_F;
                end
            end
            tfei_pkg::ST_PW_F: begin
                n_res_bpm = bpm_prod[46:32];
                n_state   = tfei_pkg::ST_FIN;
            end

            tfei_pkg::ST_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    out_load = 1'b1;
                    n_ev_cnt = '0;
                    n_fr_cnt = '0;
                    n_ev_ovf = 1'b0;
                    n_lg_ovf = 1'b0;
                    n_state  = tfei_pkg::ST_IDLE;
                end
            end

            default: n_state = tfei_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_bpm            = r_o_bpm;
    assign o_used_fallback  = r_o_fb;
    assign o_event_overflow = r_o_eovf;
    assign o_log_overflow   = r_o_lovf;

    `TFEI_ASSERT_NEXT(a_compute_busy, in_acc && i_operation == tfei_pkg::OP_COMPUTE, o_stall, "compute beat did not start the sequencer")
    `TFEI_ASSERT_NEXT(a_fin_clears, r_state == tfei_pkg::ST_FIN && out_load, r_out_valid && r_ev_cnt == '0 && r_fr_cnt == '0 && !r_ev_ovf && !r_lg_ovf, "result issue did not clear the stores")
    `TFEI_ASSERT_NOW(a_fr_bound, 1'b1, r_fr_cnt <= FR_MAX && r_ev_cnt <= EV_MAX, "store count beyond its depth")
    `TFEI_ASSERT_NOW(a_out_only_at_fin, out_load, r_state == tfei_pkg::ST_FIN, "result loaded outside the final step")

endmodule
